/* src/rdsm_pkg.sv */
package rdsm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 64;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h2E;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REARM,
        OP_ADVANCE,
        OP_CLOSE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic       append;
        logic [7:0] symbol;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_CLOSE
    } state_t;

endpackage

/* src/regex_dot_star_matcher_top.sv */
// An end-of-text request gives its registered result in the cycle after acceptance.
// After each request the block takes no new one until the closure has settled
// across every consecutive starred element the reachable set spreads to; the
// closure moves one cell pair per cycle down the cell row.
// Reset: synchronous active-low; empty pattern, no overflow, position zero reachable.
module regex_dot_star_matcher_top #(
    parameter int unsigned MAX_PATTERN = rdsm_pkg::MAX_PATTERN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_overflow
);
    import rdsm_pkg::*;

    localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
    localparam logic [LenW-1:0] LEN_MAX = LenW'(MAX_PATTERN);

    state_t          state_reg, state_next;
    logic [LenW-1:0] len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic            end_reg, end_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_matched_reg, m_matched_next;
    logic            m_overflow_reg, m_overflow_next;

    cell_ctrl_t ctrl;
    kind_t      kind;
    logic       accept;
    logic       any_change;

    logic [MAX_PATTERN-1:0] adv;
    logic [MAX_PATTERN-1:0] cls;
    logic [MAX_PATTERN-1:0] star;
    logic [MAX_PATTERN-1:0] bits;
    logic [MAX_PATTERN-1:0] chg;
    logic [MAX_PATTERN:0]   pos_bits;

    assign kind = kind_t'(s_kind);

    // Only an end-of-text request has to wait for the output register.
    assign s_ready = (state_reg == ST_IDLE) &&
                     !(kind == KIND_END && m_valid_reg && !m_ready);
    assign accept  = s_valid && s_ready;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic adv_prev;
        logic cls_prev2;
        logic star_succ;

        if (i >= 1) begin : g_adv
            assign adv_prev = adv[i-1];
        end else begin : g_adv0
            assign adv_prev = 1'b0;
        end

        if (i >= 2) begin : g_cls
            assign cls_prev2 = cls[i-2];
        end else begin : g_cls0
            assign cls_prev2 = 1'b0;
        end

        if (i + 1 < MAX_PATTERN) begin : g_star
            assign star_succ = star[i+1];
        end else begin : g_star0
            assign star_succ = 1'b0;
        end

        rdsm_cell #(
            .MaxPattern (MAX_PATTERN),
            .Index      (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .len          (len_reg),
            .adv_in       (adv_prev),
            .cls_in       (cls_prev2),
            .star_next_in (star_succ),
            .star_out     (star[i]),
            .adv_out      (adv[i]),
            .cls_out      (cls[i]),
            .bit_out      (bits[i]),
            .changed_out  (chg[i])
        );
    end

    // Every reachable position, including the one past the last cell; the
    // bit at the current pattern length tells whether the text matched.
    assign pos_bits = {end_reg, bits};

    // Control word broadcast to every cell.
    always_comb begin
        ctrl.op     = OP_HOLD;
        ctrl.append = 1'b0;
        ctrl.symbol = s_symbol;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_CLEAR:  ctrl.op = OP_REARM;
                        KIND_APPEND: begin
                            ctrl.op     = OP_REARM;
                            ctrl.append = (len_reg < LEN_MAX);
                        end
                        KIND_TEXT:   ctrl.op = OP_ADVANCE;
                        KIND_END:    ctrl.op = OP_REARM;
                        default:     ctrl.op = OP_HOLD;
                    endcase
                end
            end
            ST_CLOSE: ctrl.op = OP_CLOSE;
            default:  ctrl.op = OP_HOLD;
        endcase
    end

    // The position past the last element has no element of its own.
    always_comb begin
        unique case (ctrl.op)
            OP_HOLD:    end_next = end_reg;
            OP_REARM:   end_next = 1'b0;
            OP_ADVANCE: end_next = adv[MAX_PATTERN-1];
            OP_CLOSE:   end_next = end_reg || cls[MAX_PATTERN-2];
            default:    end_next = end_reg;
        endcase
    end

    assign any_change = (|chg) || (end_next != end_reg);

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_matched_next  = m_matched_reg;
        m_overflow_next = m_overflow_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CLOSE;
                    unique case (kind)
                        KIND_CLEAR: begin
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                        KIND_APPEND: begin
                            if (len_reg < LEN_MAX) begin
                                len_next = len_reg + LenW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_TEXT: begin
                        end
                        KIND_END: begin
                            m_valid_next    = 1'b1;
                            m_matched_next  = pos_bits[len_reg];
                            m_overflow_next = ovf_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLOSE: begin
                if (!any_change) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg  <= m_matched_next;
        m_overflow_reg <= m_overflow_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_matched  = m_matched_reg;
    assign m_overflow = m_overflow_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("pattern length beyond store depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> len_reg == LEN_MAX)
        else $error("overflow flagged with room left in the store");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("request taken during closure");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == KIND_END) |=>
            m_valid_reg && m_matched_reg == $past(pos_bits[len_reg]))
        else $error("end of text gave no result or a wrong flag");

endmodule

/* src/rdsm_cell.sv */
module rdsm_cell #(
    parameter int unsigned MaxPattern = rdsm_pkg::MAX_PATTERN_DEF,
    parameter int unsigned Index      = 0,
    localparam int unsigned LenW      = $clog2(MaxPattern + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rdsm_pkg::cell_ctrl_t ctrl,
    input  logic [LenW-1:0]      len,
    input  logic                 adv_in,
    input  logic                 cls_in,
    input  logic                 star_next_in,
    output logic                 star_out,
    output logic                 adv_out,
    output logic                 cls_out,
    output logic                 bit_out,
    output logic                 changed_out
);
    import rdsm_pkg::*;

    localparam logic [LenW-1:0] IDX      = LenW'(Index);
    localparam logic [LenW-1:0] IDX_NEXT = LenW'(Index + 1);
    localparam logic            BIT_INIT = (Index == 0);

    logic [7:0] elem_reg;
    logic       bit_reg;
    logic       bit_next;
    logic       in_pattern;
    logic       starred;
    logic       match;

    assign in_pattern = IDX < len;
    // The element is starred when the next stored byte is a star inside the pattern.
    assign starred    = (IDX_NEXT < len) && star_next_in;
    assign match      = bit_reg && in_pattern &&
                        ((elem_reg == ctrl.symbol) || (elem_reg == ANY_BYTE));

    assign star_out    = (elem_reg == STAR_BYTE);
    assign adv_out     = match && !starred;
    assign cls_out     = bit_reg && starred;
    assign bit_out     = bit_reg;
    assign changed_out = (bit_next != bit_reg);

    always_comb begin
        unique case (ctrl.op)
            OP_HOLD:    bit_next = bit_reg;
            OP_REARM:   bit_next = BIT_INIT;
            OP_ADVANCE: bit_next = adv_in || (match && starred);
            OP_CLOSE:   bit_next = bit_reg || cls_in;
            default:    bit_next = bit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= BIT_INIT;
        end else begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_REARM && ctrl.append && len == IDX) begin
            elem_reg <= ctrl.symbol;
        end
    end

endmodule
